FILE: rtl/sfur_pkg.sv
// Package for the serial firmware update receiver.
// Holds frame and page geometry, protocol characters, result kinds and register codes.
// No dependencies.
`timescale 1ns / 1ps

package sfur_pkg;

  // Frame and page geometry.
  localparam int FRAME_BYTES = 16;
  localparam int PAGE_BYTES  = 4096;
  localparam int MAX_RES     = 15;

  localparam int CNT_W     = $clog2(FRAME_BYTES + 1);
  localparam int FI_W      = $clog2(FRAME_BYTES);
  localparam int PG_W      = $clog2(PAGE_BYTES);
  localparam int RES_W     = $clog2(MAX_RES + 1);
  localparam int PAY_MAX   = FRAME_BYTES - 8;
  localparam int PAY_SLOTS = (PAY_MAX < MAX_RES) ? PAY_MAX : MAX_RES;

  // Protocol characters and address bias.
  localparam logic [7:0]  SYNC0    = 8'hA5;
  localparam logic [7:0]  SYNC1    = 8'h5A;
  localparam logic [7:0]  CH_ACK   = 8'h23;
  localparam logic [7:0]  CH_ERR   = 8'h21;
  localparam logic [7:0]  CH_START = 8'h2A;
  localparam logic [31:0] RAM_BIAS = 32'h2000_0000;

  // Register map.
  localparam int          ADDR_W       = 4;
  localparam logic [1:0]  REG_VERSION  = 2'd0;
  localparam logic [1:0]  REG_PARTSIZE = 2'd1;
  localparam logic [1:0]  REG_BASE     = 2'd2;
  localparam logic [31:0] PART_RESET   = 32'd262144;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_TX     = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_COMMIT = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_BOOT   = 3'd4
  } kind_e;

  // One result item waiting for the output side.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [11:0] offset;
    logic [31:0] addr;
  } res_t;

endpackage

FILE: rtl/serial_firmware_update_receiver.sv
// Serial firmware update receiver, top level.
// Frame assembly, checksum, page writes and the result queue; uses sfur_pkg.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid_i/in_ready_o) carries a start event (func_i = 0) or a
// received serial byte (func_i = 1, rx_byte_i). Each request is decoded in the cycle
// it is accepted, and all of its results are written into a queue of up to 15
// entries. The output channel (out_valid_o/out_ready_i) presents them one per cycle
// while out_ready_i is high, starting the cycle after acceptance; last_o marks the
// final result of a request. A request that causes no result leaves the queue empty,
// so bytes that only extend a frame flow at one per cycle. A request that causes
// results holds the queue until they are taken; the next request is accepted in the
// same cycle the last result is taken, so a byte that closes a frame waits on the
// single output port draining the queue. When the receiver stalls, the queue holds
// and in_ready_o stays low until the final result is taken. Configuration is written
// over the APB port while idle; the user must keep to this, the block does not check it.
// Reset empties the queue, clears the frame count, length, offset, checksum and the
// done flag, and loads the register reset values. The frame byte store is not reset.
module serial_firmware_update_receiver (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic [7:0]                 rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 kind_o,
  output logic [7:0]                 value_o,
  output logic [11:0]                page_offset_o,
  output logic [31:0]                flash_address_o,
  output logic                       last_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfur_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import sfur_pkg::*;

  // Registers and state.
  logic [31:0]      version_q, part_size_q, base_q;
  logic [7:0]       store_q [FRAME_BYTES];
  logic [7:0]       prev_q;
  logic [CNT_W-1:0] frame_count_q;
  logic [31:0]      total_len_q, exp_off_q;
  logic [15:0]      sum_q;
  logic             finished_q;
  res_t             res_q [MAX_RES];
  logic [RES_W-1:0] res_cnt_q;

  // Decode signals.
  logic             in_fire, out_fire, cfg_wr;
  logic [FI_W-1:0]  k0;
  logic [CNT_W-1:0] kk, psize, g_w;
  logic [7:0]       frame_nx [FRAME_BYTES];
  logic             sync_bad, frame_done, chk_ok, in_order, commit, len_bad;
  logic             g_c, g_d;
  logic [15:0]      sum_nx;
  logic [31:0]      len_val, seq_val, limit, eo_new, eo_final, commit_addr, g_v;
  logic [PG_W-1:0]  pidx;
  logic [PG_W:0]    room, pend;
  logic [CNT_W-1:0] w_cnt;
  logic [7:0]       pay [MAX_RES];
  res_t             res_d [MAX_RES];
  logic [RES_W-1:0] n_d;

  // Handshakes.
  assign out_valid_o = (res_cnt_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = (res_cnt_q == '0) || ((res_cnt_q == RES_W'(1)) && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign pready      = 1'b1;

  // Result presented from the head of the queue.
  assign kind_o          = res_q[0].kind;
  assign value_o         = res_q[0].value;
  assign page_offset_o   = res_q[0].offset;
  assign flash_address_o = res_q[0].addr;
  assign last_o          = (res_cnt_q == RES_W'(1));

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_VERSION:  prdata = version_q;
      REG_PARTSIZE: prdata = part_size_q;
      REG_BASE:     prdata = base_q;
      default:      prdata = '0;
    endcase
  end

  // Frame position and the frame with the incoming byte in place.
  always_comb begin
    k0 = (frame_count_q >= CNT_W'(FRAME_BYTES)) ? '0 : frame_count_q[FI_W-1:0];
    kk = CNT_W'(k0) + CNT_W'(1);
    for (int e = 0; e < FRAME_BYTES; e++) begin
      frame_nx[e] = (k0 == FI_W'(e)) ? rx_byte_i : store_q[e];
    end
  end

  // Frame fields, checksum and end-of-frame detection.
  always_comb begin
    sync_bad = (kk == CNT_W'(2)) && ((frame_nx[0] != SYNC0) || (frame_nx[1] != SYNC1));
    sum_nx   = sum_q;
    if ((kk >= CNT_W'(6)) && !kk[0]) begin
      sum_nx = sum_q + {rx_byte_i, prev_q};
    end
    psize = kk - CNT_W'(8);
    frame_done = ((total_len_q == '0) && (kk == CNT_W'(6))) ||
                 ((kk > CNT_W'(8)) && (total_len_q <= exp_off_q + 32'(psize))) ||
                 (kk >= CNT_W'(FRAME_BYTES));
    len_val = {frame_nx[5], frame_nx[4], frame_nx[3], frame_nx[2]};
    seq_val = {frame_nx[7], frame_nx[6], frame_nx[5], frame_nx[4]};
    limit   = (part_size_q < 32'd8) ? '0 : part_size_q - 32'd8;
    len_bad = (len_val > limit);
    chk_ok  = (sum_nx == {frame_nx[3], frame_nx[2]});
    in_order = (seq_val == exp_off_q);
  end

  // Page placement of an in-order payload.
  always_comb begin
    pidx   = seq_val[PG_W-1:0];
    room   = (PG_W+1)'(PAGE_BYTES) - {1'b0, pidx};
    w_cnt  = ((PG_W+1)'(psize) < room) ? psize : CNT_W'(room);
    pend   = {1'b0, pidx} + (PG_W+1)'(psize);
    eo_new = exp_off_q + 32'(psize);
    commit = (pend == (PG_W+1)'(PAGE_BYTES)) || (eo_new >= total_len_q);
    commit_addr = base_q - RAM_BIAS + {seq_val[31:PG_W], {PG_W{1'b0}}};
    eo_final = in_order ? eo_new : exp_off_q;
    for (int j = 0; j < MAX_RES; j++) begin
      pay[j] = '0;
    end
    for (int i = 0; i < PAY_SLOTS; i++) begin
      pay[i] = frame_nx[8 + i];
    end
  end

  // Parameters of the write/commit/ack/done sequence.
  always_comb begin
    g_w = '0;
    g_c = 1'b0;
    g_v = '0;
    g_d = 1'b0;
    if (total_len_q != '0) begin
      g_v = exp_off_q;
      if (chk_ok) begin
        g_w = in_order ? w_cnt : '0;
        g_c = in_order && commit;
        g_v = eo_final;
        g_d = (eo_final >= total_len_q);
      end
    end
  end

  // Build the result list for the request at the input.
  always_comb begin
    res_t seq6 [6];
    int   a_base;
    int   m;
    int   total;
    for (int j = 0; j < MAX_RES; j++) begin
      res_d[j] = '{kind: KIND_TX, value: 8'h00, offset: 12'h000, addr: 32'h0};
    end
    for (int j = 0; j < 6; j++) begin
      seq6[j] = '{kind: KIND_TX, value: 8'h00, offset: 12'h000, addr: 32'h0};
    end
    n_d    = '0;
    a_base = 0;
    m      = 0;
    total  = 0;
    if (!func_i) begin
      // Start announcement: optional boot confirm, '*', version MSB first.
      seq6[0].kind  = KIND_BOOT;
      seq6[1].value = CH_START;
      seq6[2].value = version_q[31:24];
      seq6[3].value = version_q[23:16];
      seq6[4].value = version_q[15:8];
      seq6[5].value = version_q[7:0];
      if (!version_q[0]) begin
        for (int j = 0; j < 6; j++) begin
          res_d[j] = seq6[j];
        end
        n_d = RES_W'(6);
      end else begin
        for (int j = 0; j < 5; j++) begin
          res_d[j] = seq6[j + 1];
        end
        n_d = RES_W'(5);
      end
    end else if (!finished_q && (kk > CNT_W'(2)) && frame_done) begin
      if ((total_len_q == '0) && len_bad) begin
        // Rejected length: four error marks and a start mark.
        for (int j = 0; j < 4; j++) begin
          res_d[j].value = CH_ERR;
        end
        res_d[4].value = CH_START;
        n_d = RES_W'(5);
      end else begin
        // Page writes, optional commit, ack of the offset, optional done.
        a_base = int'(g_w) + (g_c ? 1 : 0);
        for (int j = 0; j < MAX_RES; j++) begin
          m = j - a_base;
          if (j < int'(g_w)) begin
            res_d[j].kind   = KIND_WRITE;
            res_d[j].value  = pay[j];
            res_d[j].offset = 12'({1'b0, pidx} + (PG_W+1)'(j));
          end else if (g_c && (m == -1)) begin
            res_d[j].kind = KIND_COMMIT;
            res_d[j].addr = commit_addr;
          end else begin
            case (m)
              0:       res_d[j].value = CH_ACK;
              1:       res_d[j].value = g_v[7:0];
              2:       res_d[j].value = g_v[15:8];
              3:       res_d[j].value = g_v[23:16];
              4:       res_d[j].value = g_v[31:24];
              5:       res_d[j].kind  = KIND_DONE;
              default: res_d[j].value = 8'h00;
            endcase
          end
        end
        total = a_base + 5 + (g_d ? 1 : 0);
        n_d = (total > MAX_RES) ? RES_W'(MAX_RES) : RES_W'(total);
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q   <= '0;
      part_size_q <= PART_RESET;
      base_q      <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_VERSION:  version_q   <= pwdata;
        REG_PARTSIZE: part_size_q <= pwdata;
        REG_BASE:     base_q      <= pwdata;
        default:      ;
      endcase
    end
  end

  // Frame byte store and previous byte; written before they are read.
  always_ff @(posedge clk_i) begin
    if (in_fire && func_i && !finished_q) begin
      store_q[k0] <= rx_byte_i;
      prev_q      <= rx_byte_i;
    end
  end

  // Receive state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= '0;
      total_len_q   <= '0;
      exp_off_q     <= '0;
      sum_q         <= '0;
      finished_q    <= 1'b0;
    end else if (in_fire && func_i && !finished_q) begin
      if (kk <= CNT_W'(2)) begin
        frame_count_q <= sync_bad ? '0 : kk;
        sum_q         <= '0;
      end else if (!frame_done) begin
        frame_count_q <= kk;
        sum_q         <= sum_nx;
      end else begin
        frame_count_q <= '0;
        sum_q         <= '0;
        if (total_len_q == '0) begin
          if (!len_bad) begin
            total_len_q <= len_val;
          end
        end else if (chk_ok) begin
          exp_off_q <= eo_final;
          if (eo_final >= total_len_q) begin
            finished_q <= 1'b1;
          end
        end
      end
    end
  end

  // Result queue count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= '0;
    end else if (in_fire) begin
      res_cnt_q <= n_d;
    end else if (out_fire) begin
      res_cnt_q <= res_cnt_q - RES_W'(1);
    end
  end

  // Result queue entries: load on a request, shift as results are taken.
  always_ff @(posedge clk_i) begin
    if (in_fire && (n_d != '0)) begin
      res_q <= res_d;
    end else if (out_fire) begin
      for (int j = 0; j < MAX_RES - 1; j++) begin
        res_q[j] <= res_q[j + 1];
      end
    end
  end

  // Assertions.
  a_start_has_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !func_i) |=> out_valid_o)
    else $error("start event produced no results");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_count_q < CNT_W'(FRAME_BYTES))
    else $error("frame count out of range");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_o && !in_fire) |=> !out_valid_o)
    else $error("results remain after the last one was taken");

  a_finished_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |=> finished_q)
    else $error("done flag cleared without reset");

endmodule
